@@ rtl/srsm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package srsm_pkg;

  // Vector store geometry (depth must be a power of two)
  localparam int VEC_DEPTH = 1024;
  localparam int VEC_AW    = $clog2(VEC_DEPTH);

  // Result queue geometry
  localparam int OUT_DEPTH = 8;
  localparam int OUT_AW    = $clog2(OUT_DEPTH);

  // Item operation codes
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_MATRIX = 1'b1;

  // Register indexes on the configuration port
  localparam logic REG_ROW_FIRST = 1'b0;
  localparam logic REG_ROW_COUNT = 1'b1;

  // Saturation limits
  localparam logic signed [63:0] ACC_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] ACC_MIN = {1'b1, {63{1'b0}}};
  localparam logic signed [31:0] Q16_MAX = {1'b0, {31{1'b1}}};
  localparam logic signed [31:0] Q16_MIN = {1'b1, {31{1'b0}}};

  // Accepted item as registered alongside the vector store read
  typedef struct packed {
    logic               valid;
    logic               mac;
    logic [15:0]        row;
    logic               row_end;
    logic signed [31:0] value;
  } srsm_mac_in_t;

  // One finished row
  typedef struct packed {
    logic [15:0]        row;
    logic signed [31:0] dot;
  } srsm_result_t;

endpackage

`default_nettype wire

@@ rtl/srsm_vec_store.sv @@
`timescale 1ns / 1ps
`default_nettype none

module srsm_vec_store (
  input  wire logic                        clk,
  input  wire logic                        wr_en,
  input  wire logic [srsm_pkg::VEC_AW-1:0] wr_addr,
  input  wire logic signed [31:0]          wr_data,
  input  wire logic                        rd_en,
  input  wire logic [srsm_pkg::VEC_AW-1:0] rd_addr,
  output logic signed [31:0]               rd_data
);

  logic signed [31:0] mem [srsm_pkg::VEC_DEPTH];

  // Write one element
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/srsm_mac.sv @@
`timescale 1ns / 1ps
`default_nettype none

module srsm_mac (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire srsm_pkg::srsm_mac_in_t s1,
  input  wire logic signed [31:0]     vec_data,
  output logic                        res_valid,
  output srsm_pkg::srsm_result_t      res,
  output logic [1:0]                  inflight
);

  // Product stage
  logic               p_valid;
  logic               p_mac;
  logic               p_row_end;
  logic [15:0]        p_row;
  logic signed [63:0] p_prod;

  // Accumulator and finished-row stage
  logic signed [63:0] acc;
  logic signed [63:0] acc_next;
  logic signed [63:0] sum_raw;
  logic signed [63:0] sum_sat;
  logic               sum_ovf;
  logic               fin_valid;
  logic [15:0]        fin_row;
  logic signed [63:0] fin_sum;
  logic               fin_in_range;

  // Multiply the entry by the vector element
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= s1.valid;
    end
    p_mac     <= s1.mac;
    p_row_end <= s1.row_end;
    p_row     <= s1.row;
    p_prod    <= s1.value * vec_data;
  end

  // Saturating add into the accumulator
  always_comb begin
    sum_raw = acc + p_prod;
    sum_ovf = (acc[63] == p_prod[63]) && (sum_raw[63] != acc[63]);
    sum_sat = sum_ovf ? (acc[63] ? srsm_pkg::ACC_MIN : srsm_pkg::ACC_MAX) : sum_raw;
    acc_next = acc;
    if (p_valid && p_mac) begin
      acc_next = p_row_end ? 64'sd0 : sum_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= 64'sd0;
      fin_valid <= 1'b0;
    end else begin
      acc       <= acc_next;
      fin_valid <= p_valid && p_mac && p_row_end;
    end
    fin_row <= p_row;
    fin_sum <= sum_sat;
  end

  // Convert Q32.32 to Q16.16 with saturation
  assign fin_in_range = (fin_sum[63:47] == {17{1'b0}}) || (fin_sum[63:47] == {17{1'b1}});

  always_comb begin
    res.row = fin_row;
    if (fin_in_range) begin
      res.dot = fin_sum[47:16];
    end else begin
      res.dot = fin_sum[63] ? srsm_pkg::Q16_MIN : srsm_pkg::Q16_MAX;
    end
  end

  assign res_valid = fin_valid;

  // Count stages that will yield a result
  assign inflight = 2'(s1.valid && s1.mac && s1.row_end)
                  + 2'(p_valid && p_mac && p_row_end)
                  + 2'(fin_valid);

  // Accumulator clears after a row ends
  a_acc_clear: assert property (@(posedge clk) disable iff (rst)
    (p_valid && p_mac && p_row_end) |=> (acc == 64'sd0))
    else $error("accumulator not cleared after row end");

endmodule

`default_nettype wire

@@ rtl/srsm_out_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

module srsm_out_fifo (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         push,
  input  wire srsm_pkg::srsm_result_t       push_data,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output srsm_pkg::srsm_result_t            head,
  output logic [srsm_pkg::OUT_AW:0]         count
);

  srsm_pkg::srsm_result_t       slots [srsm_pkg::OUT_DEPTH];
  logic [srsm_pkg::OUT_AW-1:0]  wr_ptr;
  logic [srsm_pkg::OUT_AW-1:0]  rd_ptr;
  logic                         pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign head      = slots[rd_ptr];

  // Store pushed results
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (srsm_pkg::OUT_AW+1)'(push) - (srsm_pkg::OUT_AW+1)'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |-> (count < (srsm_pkg::OUT_AW+1)'(srsm_pkg::OUT_DEPTH)))
    else $error("result queue overflow");

  a_head_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(rd_ptr)))
    else $error("result dropped while stalled");

endmodule

`default_nettype wire

@@ rtl/sparse_row_slice_matvec_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Results pass the item, product and finished-row registers, then the result queue.
// Throughput: one item per cycle while in_ready is high; set by the single multiply-accumulate loop
// through the accumulator register, fed by one vector store read port.
// An 8-entry queue absorbs output stalls; input stalls when queued+in-flight reach 8.
// Reset (rst, synchronous) clears the accumulator, pipeline, queue and registers
// (row_first = 0, row_count = 65536); the vector store is not cleared.
module sparse_row_slice_matvec_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  // item input
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               op,
  input  wire logic [15:0]        row,
  input  wire logic [9:0]         col,
  input  wire logic signed [31:0] value,
  input  wire logic               row_end,
  // result output
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [15:0]             out_row,
  output logic signed [31:0]      dot_value,
  // configuration
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  logic [15:0]                  row_first;
  logic [16:0]                  row_count;
  logic                         accept;
  logic                         in_slice;
  logic [15:0]                  row_offset;
  logic [srsm_pkg::VEC_AW-1:0]  vec_addr;
  logic signed [31:0]           vec_data;
  srsm_pkg::srsm_mac_in_t       s1;
  logic                         res_valid;
  srsm_pkg::srsm_result_t       res;
  srsm_pkg::srsm_result_t       head;
  logic [1:0]                   inflight;
  logic [srsm_pkg::OUT_AW:0]    q_count;
  logic [srsm_pkg::OUT_AW+1:0]  pending;

  // Configuration registers
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_first <= 16'd0;
      row_count <= 17'h10000;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        srsm_pkg::REG_ROW_FIRST: row_first <= pwdata[15:0];
        srsm_pkg::REG_ROW_COUNT: row_count <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      srsm_pkg::REG_ROW_FIRST: prdata = {16'd0, row_first};
      srsm_pkg::REG_ROW_COUNT: prdata = {15'd0, row_count};
      default:                 prdata = 32'd0;
    endcase
  end

  // Hold input while results in flight could fill the queue
  assign pending  = (srsm_pkg::OUT_AW+2)'(q_count) + (srsm_pkg::OUT_AW+2)'(inflight);
  assign in_ready = (pending < (srsm_pkg::OUT_AW+2)'(srsm_pkg::OUT_DEPTH));
  assign accept   = in_valid && in_ready;

  // Slice check
  assign row_offset = row - row_first;
  assign in_slice   = (row >= row_first) && ({1'b0, row_offset} < row_count);
  assign vec_addr   = srsm_pkg::VEC_AW'(col);

  srsm_vec_store u_vec_store (
    .clk     (clk),
    .wr_en   (accept && (op == srsm_pkg::OP_LOAD)),
    .wr_addr (vec_addr),
    .wr_data (value),
    .rd_en   (accept && (op == srsm_pkg::OP_MATRIX)),
    .rd_addr (vec_addr),
    .rd_data (vec_data)
  );

  // Register the item alongside the store read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else begin
      s1.valid <= accept;
    end
    s1.mac     <= (op == srsm_pkg::OP_MATRIX) && in_slice;
    s1.row     <= row;
    s1.row_end <= row_end;
    s1.value   <= value;
  end

  srsm_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .s1        (s1),
    .vec_data  (vec_data),
    .res_valid (res_valid),
    .res       (res),
    .inflight  (inflight)
  );

  srsm_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head),
    .count     (q_count)
  );

  assign out_row   = head.row;
  assign dot_value = head.dot;

  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= (srsm_pkg::OUT_AW+2)'(srsm_pkg::OUT_DEPTH))
    else $error("results in flight exceed queue space");

endmodule

`default_nettype wire
